@@ design/pgb_pkg.sv @@
// ----------------------------------------------------------------------------
// pgb_pkg
// Shared types and constants of the polar grid point binning block: register
// map, reset values, arctangent table and binary angle constants.
// ----------------------------------------------------------------------------
package pgb_pkg;

    // Register and field widths
    localparam int RANGE_SQ_W = 35;
    localparam int COUNT_W    = 11;
    localparam int INDEX_W    = 10;
    localparam int CFG_IDX_W  = 2;

    // Reset values of the registers
    localparam logic [RANGE_SQ_W-1:0] MIN_SQ_RST    = '0;
    localparam logic [RANGE_SQ_W-1:0] MAX_SQ_RST    = '1;
    localparam logic [COUNT_W-1:0]    SEG_COUNT_RST = 11'd360;
    localparam logic [COUNT_W-1:0]    BIN_COUNT_RST = 11'd120;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_RANGE_SQ = 2'd0,
        REG_MAX_RANGE_SQ = 2'd1,
        REG_SEG_COUNT    = 2'd2,
        REG_BIN_COUNT    = 2'd3
    } t_cfg_reg;

    // Binary angle: 2^32 units per full turn, signed with headroom
    localparam int ANGLE_W = 34;
    localparam int OFF_W   = 33;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [ANGLE_W-1:0] FULL_TURN    = 34'sd4294967296;

    // Arctangent of 2^-i in binary angle units, rounded to nearest
    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Flags that travel with a word down the range and bin path
    typedef struct packed {
        logic valid;
        logic in_range;
        logic bin_ok;
    } t_bin_flags;

endpackage

@@ design/polar_grid_point_binning.sv @@
// ----------------------------------------------------------------------------
// polar_grid_point_binning
// Polar grid cell of a lidar point: range gate, angular segment and radial bin.
//
// Input: a point word (x, y, z) is taken at each rising edge with start high
// and busy low. busy is a register that reset sets and the first edge out of
// reset clears, so after reset one point can be taken in every cycle.
// Output: each point gives exactly one result word, shown for one cycle with
// o_done high. The latency is set by the longer of two paths: the range
// square root pipeline followed by the bin divider pipeline (the longer one
// with the default parameters), or the CORDIC segment pipeline; the shorter
// path is padded to match. Throughput is one point per cycle. The receiver
// cannot stall.
// Configuration: a register write via i_cfg_we, i_cfg_index, i_cfg_data is
// registered, then the clamped counts are too; write only while no point is in
// flight. Reset restores the register defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module polar_grid_point_binning #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int MAX_BINS     = 1024,
    parameter int COORD_BITS   = 18,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_we,
    input  logic [pgb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pgb_pkg::RANGE_SQ_W-1:0]       i_cfg_data,
    input  logic signed [COORD_BITS-1:0]         i_point_x,
    input  logic signed [COORD_BITS-1:0]         i_point_y,
    input  logic signed [COORD_BITS-1:0]         i_point_z,
    output logic                                 o_done,
    output logic                                 o_in_range,
    output logic [pgb_pkg::INDEX_W-1:0]          o_segment_index,
    output logic [pgb_pkg::INDEX_W-1:0]          o_bin_index,
    output logic [COORD_BITS-1:0]                o_planar_range,
    output logic signed [COORD_BITS-1:0]         o_height
);

    localparam int RSQ_W   = 2 * COORD_BITS;
    localparam int SQ_W    = (RSQ_W > 36) ? RSQ_W : 36;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int NS_W    = $clog2(MAX_SEGMENTS + 1);
    localparam int NB_W    = $clog2(MAX_BINS + 1);
    localparam int NUM_W   = ROOT_W + NB_W;
    localparam int OFF_W   = pgb_pkg::OFF_W;
    localparam int PROD_W  = OFF_W + NS_W;
    localparam int FLAG_W  = $bits(pgb_pkg::t_bin_flags);
    localparam int SIDE_A_W = FLAG_W + COORD_BITS;
    localparam int SIDE_B_W = FLAG_W + ROOT_W + COORD_BITS;
    localparam int PAD_B_W  = SIDE_B_W + NB_W;
    localparam int L_BIN   = 3 + ROOT_W + NB_W;
    localparam int L_SEG   = CORDIC_STEPS + 3;
    localparam int L_ALN   = (L_BIN > L_SEG) ? L_BIN : L_SEG;
    localparam int BIN_PAD = L_ALN - L_BIN;
    localparam int SEG_PAD = L_ALN - L_SEG;
    localparam int LATENCY = L_ALN + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pgb_pkg::RANGE_SQ_W-1:0] r_min_sq;
    logic [pgb_pkg::RANGE_SQ_W-1:0] r_max_sq;
    logic [pgb_pkg::COUNT_W-1:0]    r_seg_count;
    logic [pgb_pkg::COUNT_W-1:0]    r_bin_count;
    logic [NS_W-1:0]                r_ns;
    logic [NB_W-1:0]                r_nb;
    logic [NS_W-1:0]                n_ns;
    logic [NB_W-1:0]                n_nb;
    logic                           r_busy;

    // take register writes; hold busy while in reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sq    <= pgb_pkg::MIN_SQ_RST;
            r_max_sq    <= pgb_pkg::MAX_SQ_RST;
            r_seg_count <= pgb_pkg::SEG_COUNT_RST;
            r_bin_count <= pgb_pkg::BIN_COUNT_RST;
            r_busy      <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (pgb_pkg::t_cfg_reg'(i_cfg_index))
                    pgb_pkg::REG_MIN_RANGE_SQ: r_min_sq    <= i_cfg_data;
                    pgb_pkg::REG_MAX_RANGE_SQ: r_max_sq    <= i_cfg_data;
                    pgb_pkg::REG_SEG_COUNT:
                        r_seg_count <= i_cfg_data[pgb_pkg::COUNT_W-1:0];
                    pgb_pkg::REG_BIN_COUNT:
                        r_bin_count <= i_cfg_data[pgb_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy = r_busy;

    // clamp the counts to 1..max
    always_comb begin
        if (r_seg_count == '0) begin
            n_ns = NS_W'(1);
        end else if (32'(r_seg_count) > 32'(MAX_SEGMENTS)) begin
            n_ns = NS_W'(MAX_SEGMENTS);
        end else begin
            n_ns = NS_W'(r_seg_count);
        end
        if (r_bin_count == '0) begin
            n_nb = NB_W'(1);
        end else if (32'(r_bin_count) > 32'(MAX_BINS)) begin
            n_nb = NB_W'(MAX_BINS);
        end else begin
            n_nb = NB_W'(r_bin_count);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ns <= n_ns;
        r_nb <= n_nb;
    end

    // ------------------------------------------------------------------
    // Squared range
    // ------------------------------------------------------------------
    logic                    r_v1;
    logic                    r_v2;
    logic [RSQ_W-1:0]        r_sq_x;
    logic [RSQ_W-1:0]        r_sq_y;
    logic [RSQ_W-1:0]        r_rsq;
    logic [COORD_BITS-1:0]   r_z1;
    logic [COORD_BITS-1:0]   r_z2;
    logic signed [RSQ_W-1:0] w_prod_x;
    logic signed [RSQ_W-1:0] w_prod_y;
    logic [SQ_W-1:0]         w_rsq_ext;
    logic                    w_ok;

    assign w_prod_x = RSQ_W'(i_point_x) * RSQ_W'(i_point_x);
    assign w_prod_y = RSQ_W'(i_point_y) * RSQ_W'(i_point_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= start && !r_busy;
            r_v2 <= r_v1;
        end
    end

    // square, then sum
    always_ff @(posedge i_clk) begin
        r_sq_x <= RSQ_W'(w_prod_x);
        r_sq_y <= RSQ_W'(w_prod_y);
        r_z1   <= i_point_z;
        r_rsq  <= r_sq_x + r_sq_y;
        r_z2   <= r_z1;
    end

    // range gate
    assign w_rsq_ext = SQ_W'(r_rsq);
    assign w_ok = (w_rsq_ext > SQ_W'(r_min_sq)) && (w_rsq_ext < SQ_W'(r_max_sq));

    // ------------------------------------------------------------------
    // Square roots of the point range and the two limits
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0]     w_root;
    logic [ROOT_W-1:0]     w_rmin;
    logic [ROOT_W-1:0]     w_rmax;
    pgb_pkg::t_bin_flags   w_flags_a_in;
    pgb_pkg::t_bin_flags   w_flags_a;
    logic [COORD_BITS-1:0] w_z_a;
    logic [SIDE_A_W-1:0]   w_side_a;

    pgb_sqrt #(.IN_W(SQ_W)) u_sqrt_range (
        .i_clk  (i_clk),
        .i_rad  (w_rsq_ext),
        .o_root (w_root)
    );

    pgb_sqrt #(.IN_W(SQ_W)) u_sqrt_min (
        .i_clk  (i_clk),
        .i_rad  (SQ_W'(r_min_sq)),
        .o_root (w_rmin)
    );

    pgb_sqrt #(.IN_W(SQ_W)) u_sqrt_max (
        .i_clk  (i_clk),
        .i_rad  (SQ_W'(r_max_sq)),
        .o_root (w_rmax)
    );

    assign w_flags_a_in = '{valid: r_v2, in_range: w_ok, bin_ok: 1'b0};

    pgb_delay #(.WIDTH(SIDE_A_W), .DEPTH(ROOT_W)) u_delay_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  ({w_flags_a_in, r_z2}),
        .o_data  (w_side_a)
    );

    assign {w_flags_a, w_z_a} = w_side_a;

    // ------------------------------------------------------------------
    // Radial bin: scale the offset, then divide by the span
    // ------------------------------------------------------------------
    pgb_pkg::t_bin_flags   r_flags3;
    pgb_pkg::t_bin_flags   n_flags3;
    logic [ROOT_W-1:0]     r_root3;
    logic [COORD_BITS-1:0] r_z3;
    logic [NUM_W-1:0]      r_num;
    logic [ROOT_W-1:0]     r_den;
    logic [ROOT_W-1:0]     w_diff;
    logic [NUM_W-1:0]      w_num;
    logic [NB_W-1:0]       w_quot;
    logic [SIDE_B_W-1:0]   w_side_b;

    assign w_diff = w_root - w_rmin;
    assign w_num  = NUM_W'(w_diff) * NUM_W'(r_nb);

    always_comb begin
        n_flags3        = w_flags_a;
        n_flags3.bin_ok = w_flags_a.in_range && (w_rmax > w_rmin) && (w_root > w_rmin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags3 <= '0;
        end else begin
            r_flags3 <= n_flags3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root3 <= w_root;
        r_z3    <= w_z_a;
        r_num   <= w_num;
        r_den   <= w_rmax - w_rmin;
    end

    pgb_divider #(.DEN_W(ROOT_W), .Q_W(NB_W)) u_divider (
        .i_clk  (i_clk),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_quot (w_quot)
    );

    pgb_delay #(.WIDTH(SIDE_B_W), .DEPTH(NB_W)) u_delay_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  ({r_flags3, r_root3, r_z3}),
        .o_data  (w_side_b)
    );

    // ------------------------------------------------------------------
    // Angular segment
    // ------------------------------------------------------------------
    logic signed [pgb_pkg::ANGLE_W-1:0] w_angle;
    logic signed [pgb_pkg::ANGLE_W-1:0] w_off;
    logic [OFF_W-1:0]                   w_off_clamp;
    logic [PROD_W-1:0]                  r_seg_prod;
    logic [NS_W:0]                      w_seg_hi;
    logic [NS_W-1:0]                    r_seg;
    logic [NS_W-1:0]                    w_seg_aln;

    pgb_cordic #(.COORD_BITS(COORD_BITS), .STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .o_angle (w_angle)
    );

    // shift the angle to [0, full turn]
    assign w_off = w_angle + pgb_pkg::HALF_TURN;
    always_comb begin
        if (w_off < 0) begin
            w_off_clamp = '0;
        end else if (w_off > pgb_pkg::FULL_TURN) begin
            w_off_clamp = pgb_pkg::FULL_TURN[OFF_W-1:0];
        end else begin
            w_off_clamp = w_off[OFF_W-1:0];
        end
    end

    // scale by the segment count, then saturate at count-1
    assign w_seg_hi = r_seg_prod[PROD_W-1:OFF_W-1];

    always_ff @(posedge i_clk) begin
        r_seg_prod <= PROD_W'(w_off_clamp) * PROD_W'(r_ns);
        if (w_seg_hi >= (NS_W+1)'(r_ns)) begin
            r_seg <= r_ns - NS_W'(1);
        end else begin
            r_seg <= w_seg_hi[NS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Align both paths
    // ------------------------------------------------------------------
    logic [PAD_B_W-1:0]    w_pad_b;
    pgb_pkg::t_bin_flags   w_flags_f;
    logic [ROOT_W-1:0]     w_root_f;
    logic [COORD_BITS-1:0] w_z_f;
    logic [NB_W-1:0]       w_quot_f;
    logic [NB_W-1:0]       w_bin_sat;

    pgb_delay #(.WIDTH(PAD_B_W), .DEPTH(BIN_PAD)) u_pad_bin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  ({w_side_b, w_quot}),
        .o_data  (w_pad_b)
    );

    pgb_delay #(.WIDTH(NS_W), .DEPTH(SEG_PAD)) u_pad_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (r_seg),
        .o_data  (w_seg_aln)
    );

    assign {w_flags_f, w_root_f, w_z_f, w_quot_f} = w_pad_b;
    assign w_bin_sat = (w_quot_f >= r_nb) ? (r_nb - NB_W'(1)) : w_quot_f;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                          r_done;
    logic                          r_in_range;
    logic [pgb_pkg::INDEX_W-1:0]   r_seg_idx;
    logic [pgb_pkg::INDEX_W-1:0]   r_bin_idx;
    logic [COORD_BITS-1:0]         r_range;
    logic [COORD_BITS-1:0]         r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_flags_f.valid;
        end
    end

    // drop indices of rejected points
    always_ff @(posedge i_clk) begin
        r_in_range <= w_flags_f.in_range;
        r_seg_idx  <= w_flags_f.in_range ? pgb_pkg::INDEX_W'(w_seg_aln) : '0;
        r_bin_idx  <= w_flags_f.bin_ok ? pgb_pkg::INDEX_W'(w_bin_sat) : '0;
        r_range    <= w_root_f[COORD_BITS-1:0];
        r_height   <= w_z_f;
    end

    assign o_done          = r_done;
    assign o_in_range      = r_in_range;
    assign o_segment_index = r_seg_idx;
    assign o_bin_index     = r_bin_idx;
    assign o_planar_range  = r_range;
    assign o_height        = signed'(r_height);

`ifndef ASSERT_OFF
    // every result word comes from a point taken a full latency earlier
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result word without matching point");

    // a rejected point carries zero indices
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_in_range) |-> (o_segment_index == '0 && o_bin_index == '0))
        else $error("rejected point with nonzero cell");

    // an accepted point lies strictly outside the inner radius, so its range is nonzero
    a_range_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_in_range) |-> (o_planar_range != '0))
        else $error("accepted point with zero range");

    // no point is taken while reset holds busy
    a_busy_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");
`endif

endmodule

@@ design/pgb_delay.sv @@
// ----------------------------------------------------------------------------
// pgb_delay
// Fixed-length delay line that keeps side data aligned with the arithmetic
// units. The whole line clears on reset so no stale valid bit escapes.
// ----------------------------------------------------------------------------
module pgb_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    generate
        if (DEPTH == 0) begin : g_none
            // zero length: pass straight on
            assign o_data = i_data;
        end else begin : g_line
            logic [WIDTH-1:0] r_line [DEPTH];

            // shift one place per cycle
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_line <= '{default: '0};
                end else begin
                    r_line[0] <= i_data;
                    for (int k = 1; k < DEPTH; k++) begin
                        r_line[k] <= r_line[k-1];
                    end
                end
            end

            assign o_data = r_line[DEPTH-1];
        end
    endgenerate

endmodule

@@ design/pgb_sqrt.sv @@
// ----------------------------------------------------------------------------
// pgb_sqrt
// Pipelined integer square root, one result bit per stage (restoring
// digit method); it takes one radicand per cycle.
// ----------------------------------------------------------------------------
module pgb_sqrt #(
    parameter int IN_W = 36
) (
    input  logic              i_clk,
    input  logic [IN_W-1:0]   i_rad,
    output logic [IN_W/2-1:0] o_root
);

    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 3;

    logic [REM_W-1:0] r_rem  [OUT_W];
    logic [REM_W-1:0] n_rem  [OUT_W];
    logic [OUT_W-1:0] r_root [OUT_W];
    logic [OUT_W-1:0] n_root [OUT_W];
    logic [IN_W-1:0]  r_rad  [OUT_W];
    logic [IN_W-1:0]  n_rad  [OUT_W];

    // bring down two radicand bits and try the next root bit in each stage
    always_comb begin
        logic [REM_W-1:0] v_rem;
        logic [REM_W-1:0] v_sh;
        logic [REM_W-1:0] v_trial;
        logic [OUT_W-1:0] v_root;
        logic [IN_W-1:0]  v_rad;
        int               v_idx;
        for (int k = 0; k < OUT_W; k++) begin
            v_idx  = (k == 0) ? 0 : k - 1;
            v_rem  = (k == 0) ? '0 : r_rem[v_idx];
            v_root = (k == 0) ? '0 : r_root[v_idx];
            v_rad  = (k == 0) ? i_rad : r_rad[v_idx];
            v_sh    = {v_rem[REM_W-3:0], v_rad[IN_W-1 -: 2]};
            v_trial = {1'b0, v_root, 2'b01};
            if (v_sh >= v_trial) begin
                n_rem[k]  = v_sh - v_trial;
                n_root[k] = {v_root[OUT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = v_sh;
                n_root[k] = {v_root[OUT_W-2:0], 1'b0};
            end
            n_rad[k] = {v_rad[IN_W-3:0], 2'b00};
        end
    end

    // advance all stages
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_rad  <= n_rad;
    end

    assign o_root = r_root[OUT_W-1];

endmodule

@@ design/pgb_divider.sv @@
// ----------------------------------------------------------------------------
// pgb_divider
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit in Q_W bits; one division per cycle.
// ----------------------------------------------------------------------------
module pgb_divider #(
    parameter int DEN_W = 18,
    parameter int Q_W   = 11
) (
    input  logic                   i_clk,
    input  logic [DEN_W+Q_W-1:0]   i_num,
    input  logic [DEN_W-1:0]       i_den,
    output logic [Q_W-1:0]         o_quot
);

    localparam int NUM_W = DEN_W + Q_W;

    logic [NUM_W-1:0] r_rem  [Q_W];
    logic [NUM_W-1:0] n_rem  [Q_W];
    logic [DEN_W-1:0] r_den  [Q_W];
    logic [DEN_W-1:0] n_den  [Q_W];
    logic [Q_W-1:0]   r_quot [Q_W];
    logic [Q_W-1:0]   n_quot [Q_W];

    // compare against the shifted divisor, subtract where it fits
    always_comb begin
        logic [NUM_W-1:0] v_rem;
        logic [NUM_W-1:0] v_dsh;
        logic [DEN_W-1:0] v_den;
        logic [Q_W-1:0]   v_quot;
        int               v_idx;
        for (int k = 0; k < Q_W; k++) begin
            v_idx  = (k == 0) ? 0 : k - 1;
            v_rem  = (k == 0) ? i_num : r_rem[v_idx];
            v_den  = (k == 0) ? i_den : r_den[v_idx];
            v_quot = (k == 0) ? '0 : r_quot[v_idx];
            v_dsh  = NUM_W'(v_den) << (Q_W - 1 - k);
            if (v_rem >= v_dsh) begin
                n_rem[k]  = v_rem - v_dsh;
                n_quot[k] = {v_quot[Q_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = v_rem;
                n_quot[k] = {v_quot[Q_W-2:0], 1'b0};
            end
            n_den[k] = v_den;
        end
    end

    // advance all stages
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_quot = r_quot[Q_W-1];

endmodule

@@ design/pgb_cordic.sv @@
// ----------------------------------------------------------------------------
// pgb_cordic
// Pipelined vectoring CORDIC giving the binary angle of (x, y). A fold stage
// turns the point into the right half plane, then one micro-rotation per
// stage, one point per cycle.
// ----------------------------------------------------------------------------
module pgb_cordic #(
    parameter int COORD_BITS = 18,
    parameter int STEPS      = 16
) (
    input  logic                                i_clk,
    input  logic signed [COORD_BITS-1:0]        i_x,
    input  logic signed [COORD_BITS-1:0]        i_y,
    output logic signed [pgb_pkg::ANGLE_W-1:0]  o_angle
);

    localparam int XW = COORD_BITS + 11;
    localparam int AW = pgb_pkg::ANGLE_W;

    logic signed [XW-1:0] r_x   [STEPS+1];
    logic signed [XW-1:0] n_x   [STEPS+1];
    logic signed [XW-1:0] r_y   [STEPS+1];
    logic signed [XW-1:0] n_y   [STEPS+1];
    logic signed [AW-1:0] r_acc [STEPS+1];
    logic signed [AW-1:0] n_acc [STEPS+1];

    always_comb begin
        logic signed [XW-1:0] v_x;
        logic signed [XW-1:0] v_y;
        logic signed [XW-1:0] v_xs;
        logic signed [XW-1:0] v_ys;
        logic signed [AW-1:0] v_atan;

        // fold the left half plane by a quarter turn, then scale by 256
        v_x = XW'(i_x);
        v_y = XW'(i_y);
        n_acc[0] = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                v_x      = XW'(i_y);
                v_y      = -XW'(i_x);
                n_acc[0] = pgb_pkg::QUARTER_TURN;
            end else begin
                v_x      = -XW'(i_y);
                v_y      = XW'(i_x);
                n_acc[0] = -pgb_pkg::QUARTER_TURN;
            end
        end
        n_x[0] = v_x <<< 8;
        n_y[0] = v_y <<< 8;

        // one micro-rotation per stage, toward y = 0
        for (int k = 0; k < STEPS; k++) begin
            v_xs   = r_x[k] >>> k;
            v_ys   = r_y[k] >>> k;
            v_atan = signed'(AW'(pgb_pkg::ATAN_TURN[k]));
            if (r_y[k] >= 0) begin
                n_x[k+1]   = r_x[k] + v_ys;
                n_y[k+1]   = r_y[k] - v_xs;
                n_acc[k+1] = r_acc[k] + v_atan;
            end else begin
                n_x[k+1]   = r_x[k] - v_ys;
                n_y[k+1]   = r_y[k] + v_xs;
                n_acc[k+1] = r_acc[k] - v_atan;
            end
        end
    end

    // advance all stages
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
    end

    assign o_angle = r_acc[STEPS];

endmodule
